// ===== design/ita_pkg.sv =====
package ita_pkg;

    localparam int unsigned HEX_DIGITS = 16;
    localparam int unsigned DEC_DIGITS = 10;
    localparam int unsigned DEC_BITS   = 32;
    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned REMAIN_W   = 4;
    localparam int unsigned CONV_W     = 5;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h37;  // 'A' minus ten

    localparam logic OP_HEX = 1'b0;
    localparam logic OP_DEC = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREFIX,
        ST_CONV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

    function automatic logic [CHAR_W-1:0] glyph(input logic [3:0] d);
        logic [CHAR_W-1:0] res;
        if (d < 4'd10) begin
            res = CHAR_ZERO + {3'b000, d};
        end else begin
            res = CHAR_ALPHA + {3'b000, d};
        end
        return res;
    endfunction

endpackage

// ===== design/ita_bcd_cell.sv =====
module ita_bcd_cell (
    input  logic               aclk,
    input  ita_pkg::cell_ctrl_t ctrl,
    input  logic               bit_in,
    input  logic [3:0]         digit_in,
    output logic               carry_out,
    output logic [3:0]         digit
);

    logic [3:0] digit_reg;
    logic [3:0] adj;

    // add-3 correction before the doubling step
    assign adj       = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry_out = adj[3];
    assign digit     = digit_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            digit_reg <= 4'd0;
        end else if (ctrl.dabble) begin
            digit_reg <= {adj[2:0], bit_in};
        end else if (ctrl.shift) begin
            digit_reg <= digit_in;
        end
    end

endmodule

// ===== design/integer_to_ascii_formatter.sv =====
// Formats one number per input beat as ASCII text, one character per output
// beat, with m_tlast on the final character. s_tuser low selects hex ("0x"
// then uppercase digits of all 64 bits, leading zeros dropped, at least one
// digit); s_tuser high selects unsigned decimal of s_tdata[31:0]. One number
// is handled at a time: s_tready is high only while the block is idle. In hex
// each skipped leading zero takes a step, same as a digit, but sends nothing.
// Decimal runs a row of ten BCD digit cells through a shift-and-add-3 pass
// over all 32 bits, then shifts the digits out, zeros first dropped. A low
// m_tready holds the prefix and each digit that is sent until it is taken.
module integer_to_ascii_formatter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] number_value
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] ascii_char, [7] zero pad
    output logic        m_tlast    // last_char
);

    localparam int unsigned ND = ita_pkg::DEC_DIGITS;

    ita_pkg::state_t state_reg, state_next;

    logic [ita_pkg::VALUE_W-1:0]  val_reg, val_next;
    logic [ita_pkg::REMAIN_W-1:0] remain_reg, remain_next;
    logic [ita_pkg::CONV_W-1:0]   conv_reg, conv_next;
    logic                         is_hex_reg, is_hex_next;
    logic                         pfx_reg, pfx_next;
    logic                         started_reg, started_next;
    logic                         m_valid_reg, m_valid_next;
    logic [ita_pkg::CHAR_W-1:0]   m_char_reg, m_char_next;
    logic                         m_last_reg, m_last_next;

    ita_pkg::cell_ctrl_t cell_ctrl;
    logic [ND-1:0]       carry;
    logic [3:0]          digit_chain [ND];

    logic       accept;
    logic       slot_free;
    logic [3:0] cur_digit;
    logic       at_last;
    logic       skip;
    logic       emit_fire;
    logic       prefix_fire;
    logic       digit_adv;

    genvar gi;
    generate
        for (gi = 0; gi < ND; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                ita_bcd_cell u_cell (
                    .aclk      (aclk),
                    .ctrl      (cell_ctrl),
                    .bit_in    (val_reg[ita_pkg::VALUE_W-1]),
                    .digit_in  (4'd0),
                    .carry_out (carry[gi]),
                    .digit     (digit_chain[gi])
                );
            end else begin : g_rest
                ita_bcd_cell u_cell (
                    .aclk      (aclk),
                    .ctrl      (cell_ctrl),
                    .bit_in    (carry[gi-1]),
                    .digit_in  (digit_chain[gi-1]),
                    .carry_out (carry[gi]),
                    .digit     (digit_chain[gi])
                );
            end
        end
    endgenerate

    assign s_tready  = (state_reg == ita_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;

    assign cur_digit = is_hex_reg ? val_reg[ita_pkg::VALUE_W-1 -: 4] : digit_chain[ND-1];
    assign at_last   = (remain_reg == '0);
    assign skip      = (state_reg == ita_pkg::ST_EMIT) && (cur_digit == 4'd0)
                       && !started_reg && !at_last;
    assign emit_fire   = (state_reg == ita_pkg::ST_EMIT) && !skip && slot_free;
    assign prefix_fire = (state_reg == ita_pkg::ST_PREFIX) && slot_free;
    assign digit_adv   = skip || emit_fire;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_last_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ita_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser == ita_pkg::OP_DEC) ? ita_pkg::ST_CONV
                                                              : ita_pkg::ST_PREFIX;
                end
            end
            ita_pkg::ST_PREFIX: begin
                if (prefix_fire && pfx_reg) begin
                    state_next = ita_pkg::ST_EMIT;
                end
            end
            ita_pkg::ST_CONV: begin
                if (conv_reg == '0) begin
                    state_next = ita_pkg::ST_EMIT;
                end
            end
            ita_pkg::ST_EMIT: begin
                if (emit_fire && at_last) begin
                    state_next = ita_pkg::ST_IDLE;
                end
            end
            default: state_next = ita_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        val_next     = val_reg;
        remain_next  = remain_reg;
        conv_next    = conv_reg;
        is_hex_next  = is_hex_reg;
        pfx_next     = pfx_reg;
        started_next = started_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        cell_ctrl    = '0;

        case (state_reg)
            ita_pkg::ST_IDLE: begin
                if (accept) begin
                    is_hex_next    = (s_tuser == ita_pkg::OP_HEX);
                    // decimal bits leave from the top, so park them there
                    val_next       = (s_tuser == ita_pkg::OP_DEC)
                                     ? {s_tdata[ita_pkg::DEC_BITS-1:0],
                                        {(ita_pkg::VALUE_W - ita_pkg::DEC_BITS){1'b0}}}
                                     : s_tdata;
                    conv_next      = ita_pkg::CONV_W'(ita_pkg::DEC_BITS - 1);
                    pfx_next       = 1'b0;
                    started_next   = 1'b0;
                    cell_ctrl.clear = 1'b1;
                end
            end
            ita_pkg::ST_PREFIX: begin
                if (prefix_fire) begin
                    m_valid_next = 1'b1;
                    m_char_next  = pfx_reg ? ita_pkg::CHAR_X : ita_pkg::CHAR_ZERO;
                    m_last_next  = 1'b0;
                    pfx_next     = 1'b1;
                    remain_next  = ita_pkg::REMAIN_W'(ita_pkg::HEX_DIGITS - 1);
                end
            end
            ita_pkg::ST_CONV: begin
                cell_ctrl.dabble = 1'b1;
                val_next    = {val_reg[ita_pkg::VALUE_W-2:0], 1'b0};
                conv_next   = conv_reg - 1'b1;
                remain_next = ita_pkg::REMAIN_W'(ND - 1);
            end
            ita_pkg::ST_EMIT: begin
                if (digit_adv) begin
                    remain_next = remain_reg - 1'b1;
                    if (is_hex_reg) begin
                        val_next = {val_reg[ita_pkg::VALUE_W-5:0], 4'd0};
                    end else begin
                        cell_ctrl.shift = 1'b1;
                    end
                end
                if (emit_fire) begin
                    m_valid_next = 1'b1;
                    m_char_next  = ita_pkg::glyph(cur_digit);
                    m_last_next  = at_last;
                    started_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ita_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg     <= val_next;
        remain_reg  <= remain_next;
        conv_reg    <= conv_next;
        is_hex_reg  <= is_hex_next;
        pfx_reg     <= pfx_next;
        started_reg <= started_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

    // a 32-bit value always fits in ten digits
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ita_pkg::ST_CONV) |-> !carry[ND-1])
        else $error("BCD top cell overflowed");

    a_conv_is_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ita_pkg::ST_CONV) |-> !is_hex_reg)
        else $error("conversion pass in hex mode");

    a_hex_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == ita_pkg::OP_HEX)) |=> (state_reg == ita_pkg::ST_PREFIX))
        else $error("hex number did not start with prefix");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && at_last) |=> (state_reg == ita_pkg::ST_IDLE) && m_valid_reg && m_last_reg)
        else $error("last character did not end the number");

    a_dec_remain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ita_pkg::ST_EMIT && !is_hex_reg) |-> (remain_reg <= 4'(ND - 1)))
        else $error("decimal digit count out of range");

endmodule
